### hdl/ulce_pkg.sv
// ============================================================================
// UART line command echo package
// Shared codes, command and status structures and command string tables.
// ============================================================================
package ulce_pkg;

  localparam logic [1:0] REQ_RX       = 2'd0;
  localparam logic [1:0] REQ_TX_READY = 2'd1;
  localparam logic [1:0] REQ_TICK     = 2'd2;

  localparam logic [1:0] ACT_NONE        = 2'd0;
  localparam logic [1:0] ACT_TIMER_START = 2'd1;
  localparam logic [1:0] ACT_TIMER_STOP  = 2'd2;
  localparam logic [1:0] ACT_ECHO        = 2'd3;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_NL     = 8'h0A;

  localparam logic [3:0] CMP_LEN_START = 4'd11;
  localparam logic [3:0] CMP_LEN_STOP  = 4'd10;

  typedef struct packed {
    logic latch;
    logic exec;
    logic cmp_step;
    logic echo_cap;
    logic out_load;
  } ulce_cmd_t;

  typedef struct packed {
    logic line_end;
    logic echo_rd;
    logic cmp_last;
  } ulce_status_t;

  function automatic logic [7:0] start_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h24;
      4'd1:    c = 8'h54;
      4'd2:    c = 8'h49;
      4'd3:    c = 8'h4D;
      4'd4:    c = 8'h45;
      4'd5:    c = 8'h52;
      4'd6:    c = 8'h53;
      4'd7:    c = 8'h54;
      4'd8:    c = 8'h41;
      4'd9:    c = 8'h52;
      4'd10:   c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] stop_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h24;
      4'd1:    c = 8'h54;
      4'd2:    c = 8'h49;
      4'd3:    c = 8'h4D;
      4'd4:    c = 8'h45;
      4'd5:    c = 8'h52;
      4'd6:    c = 8'h53;
      4'd7:    c = 8'h54;
      4'd8:    c = 8'h4F;
      4'd9:    c = 8'h50;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### hdl/ulce_if.sv
// ============================================================================
// UART line command echo channel interfaces
// Valid/ready channels for event transactions and result transactions.
// ============================================================================
interface ulce_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface ulce_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       timer_running;
  logic       listening;
  logic [1:0] line_action;

  modport source (
    output valid, output tx_valid, output tx_byte, output timer_running,
    output listening, output line_action, input ready
  );
  modport sink (
    input valid, input tx_valid, input tx_byte, input timer_running,
    input listening, input line_action, output ready
  );
endinterface

### hdl/ulce_ram.sv
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module ulce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/ulce_ctrl.sv
// ============================================================================
// UART line command echo controller
// Sequences accept, execute, prefix compare, echo read and result load.
// ============================================================================
module ulce_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  ulce_pkg::ulce_status_t status_i,
  output ulce_pkg::ulce_cmd_t    cmd_o
);
  import ulce_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CMP,
    ST_ECHO_RD,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.latch    = (state_q == ST_IDLE) && in_ready_q && in_valid_i;
    cmd_o.exec     = (state_q == ST_EXEC);
    cmd_o.cmp_step = (state_q == ST_CMP);
    cmd_o.echo_cap = (state_q == ST_ECHO_RD);
    cmd_o.out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && in_ready_q) begin
            in_ready_q <= 1'b0;
            state_q    <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (status_i.line_end) begin
            state_q <= ST_CMP;
          end else if (status_i.echo_rd) begin
            state_q <= ST_ECHO_RD;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_CMP: begin
          if (status_i.cmp_last) begin
            state_q <= ST_DONE;
          end
        end
        ST_ECHO_RD: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            in_ready_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          in_ready_q <= 1'b1;
          state_q    <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_q |-> state_q == ST_IDLE)
    else $error("input ready outside idle state");

  a_exec_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_q |=> state_q == ST_EXEC)
    else $error("accepted transaction not executed");

  a_cmp_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) && status_i.cmp_last |=> state_q == ST_DONE)
    else $error("prefix compare did not finish");

endmodule

### hdl/ulce_dp.sv
// ============================================================================
// UART line command echo datapath
// Line store, write and send counters, mode flags, prefix compare and
// result register.
// ============================================================================
module ulce_dp #(
  parameter int LINE_LEN = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ulce_pkg::ulce_cmd_t    cmd_i,
  output ulce_pkg::ulce_status_t status_o,
  input  logic [1:0]            req_type_i,
  input  logic [7:0]            rx_byte_i,
  output logic                  tx_valid_o,
  output logic [7:0]            tx_byte_o,
  output logic                  timer_running_o,
  output logic                  listening_o,
  output logic [1:0]            line_action_o
);
  import ulce_pkg::*;

  localparam int AW = $clog2(LINE_LEN);
  localparam int CW = $clog2(LINE_LEN + 1);

  logic [1:0]    req_q;
  logic [7:0]    byte_q;
  logic [AW-1:0] wcount_q, wcount_d;
  logic [CW-1:0] saved_len_q, saved_len_d;
  logic [CW-1:0] send_idx_q, send_idx_d;
  logic          rx_en_q, rx_en_d;
  logic          tx_en_q, tx_en_d;
  logic          timer_q, timer_d;
  logic [3:0]    cmp_idx_q, cmp_idx_d;
  logic          start_ok_q, start_ok_d;
  logic          stop_ok_q, stop_ok_d;
  logic          res_txv_q, res_txv_d;
  logic [7:0]    res_byte_q, res_byte_d;
  logic [1:0]    res_act_q, res_act_d;

  logic          tx_valid_q;
  logic [7:0]    tx_byte_q;
  logic          timer_running_q;
  logic          listening_q;
  logic [1:0]    line_action_q;

  logic          rx_take;
  logic          line_end;
  logic          echo_rd;
  logic          cmp_last;
  logic [CW-1:0] wnext;
  logic [3:0]    chk_idx;
  logic          start_all;
  logic          stop_all;

  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  ulce_ram #(
    .WIDTH (8),
    .DEPTH (LINE_LEN)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wcount_q),
    .wdata_i (byte_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    rx_take   = (req_q == REQ_RX) && rx_en_q &&
                !((byte_q != CHAR_DOLLAR) && (wcount_q == '0));
    line_end  = rx_take && (byte_q == CHAR_NL);
    echo_rd   = (req_q == REQ_TX_READY) && tx_en_q && (send_idx_q < saved_len_q);
    wnext     = CW'(wcount_q) + CW'(1);
    cmp_last  = (cmp_idx_q == CMP_LEN_START);
    chk_idx   = cmp_idx_q - 4'd1;
    start_all = start_ok_q &&
                ((cmp_idx_q == 4'd0) || (ram_rdata == start_char(chk_idx)));
    stop_all  = stop_ok_q &&
                ((cmp_idx_q == 4'd0) || (chk_idx >= CMP_LEN_STOP) ||
                 (ram_rdata == stop_char(chk_idx)));
    ram_we    = cmd_i.exec && rx_take;
    ram_re    = (cmd_i.exec && echo_rd) ||
                (cmd_i.cmp_step && (cmp_idx_q < CMP_LEN_START));
    ram_raddr = cmd_i.cmp_step ? AW'(cmp_idx_q) : send_idx_q[AW-1:0];
  end

  always_comb begin
    status_o          = '0;
    status_o.line_end = line_end;
    status_o.echo_rd  = echo_rd;
    status_o.cmp_last = cmp_last;
  end

  always_comb begin
    wcount_d    = wcount_q;
    saved_len_d = saved_len_q;
    send_idx_d  = send_idx_q;
    rx_en_d     = rx_en_q;
    tx_en_d     = tx_en_q;
    timer_d     = timer_q;
    cmp_idx_d   = cmp_idx_q;
    start_ok_d  = start_ok_q;
    stop_ok_d   = stop_ok_q;
    res_txv_d   = res_txv_q;
    res_byte_d  = res_byte_q;
    res_act_d   = res_act_q;

    if (cmd_i.exec) begin
      res_txv_d  = 1'b0;
      res_byte_d = 8'h00;
      res_act_d  = ACT_NONE;
      cmp_idx_d  = 4'd0;
      start_ok_d = 1'b1;
      stop_ok_d  = 1'b1;
      case (req_q)
        REQ_RX: begin
          if (rx_take) begin
            if (line_end) begin
              saved_len_d = wnext;
              wcount_d    = '0;
            end else if (wnext == CW'(LINE_LEN)) begin
              wcount_d = '0;
            end else begin
              wcount_d = wnext[AW-1:0];
            end
          end
        end
        REQ_TX_READY: begin
          if (tx_en_q) begin
            if (echo_rd) begin
              res_txv_d  = 1'b1;
              send_idx_d = send_idx_q + CW'(1);
            end else begin
              send_idx_d = '0;
              tx_en_d    = 1'b0;
              rx_en_d    = 1'b1;
            end
          end
        end
        REQ_TICK: begin
          if (timer_q) begin
            rx_en_d    = 1'b0;
            tx_en_d    = 1'b1;
            res_txv_d  = 1'b1;
            res_byte_d = CHAR_NL;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.cmp_step) begin
      cmp_idx_d  = cmp_idx_q + 4'd1;
      start_ok_d = start_all;
      stop_ok_d  = stop_all;
      if (cmp_last) begin
        if (start_all) begin
          timer_d   = 1'b1;
          res_act_d = ACT_TIMER_START;
        end else if (stop_all) begin
          timer_d   = 1'b0;
          res_act_d = ACT_TIMER_STOP;
        end else begin
          rx_en_d   = 1'b0;
          tx_en_d   = 1'b1;
          res_act_d = ACT_ECHO;
        end
      end
    end

    if (cmd_i.echo_cap) begin
      res_byte_d = ram_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcount_q    <= '0;
      saved_len_q <= '0;
      send_idx_q  <= '0;
      rx_en_q     <= 1'b1;
      tx_en_q     <= 1'b0;
      timer_q     <= 1'b0;
      cmp_idx_q   <= '0;
      start_ok_q  <= 1'b0;
      stop_ok_q   <= 1'b0;
      res_txv_q   <= 1'b0;
      res_byte_q  <= '0;
      res_act_q   <= ACT_NONE;
    end else begin
      wcount_q    <= wcount_d;
      saved_len_q <= saved_len_d;
      send_idx_q  <= send_idx_d;
      rx_en_q     <= rx_en_d;
      tx_en_q     <= tx_en_d;
      timer_q     <= timer_d;
      cmp_idx_q   <= cmp_idx_d;
      start_ok_q  <= start_ok_d;
      stop_ok_q   <= stop_ok_d;
      res_txv_q   <= res_txv_d;
      res_byte_q  <= res_byte_d;
      res_act_q   <= res_act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q  <= req_type_i;
      byte_q <= rx_byte_i;
    end
    if (cmd_i.out_load) begin
      tx_valid_q      <= res_txv_q;
      tx_byte_q       <= res_byte_q;
      timer_running_q <= timer_q;
      listening_q     <= rx_en_q;
      line_action_q   <= res_act_q;
    end
  end

  assign tx_valid_o      = tx_valid_q;
  assign tx_byte_o       = tx_byte_q;
  assign timer_running_o = timer_running_q;
  assign listening_o     = listening_q;
  assign line_action_o   = line_action_q;

  a_rx_tx_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_en_q != tx_en_q)
    else $error("reception and transmission enabled together or both off");

  a_send_idle_when_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_en_q |-> send_idx_q == '0)
    else $error("send index not cleared while listening");

  a_wcount_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(wcount_q) < LINE_LEN)
    else $error("write position beyond line store");

endmodule

### hdl/uart_line_command_echo_top.sv
// ============================================================================
// UART line command echo top level
// Collects a '$' line, starts or stops the periodic timer on a command
// prefix, and otherwise echoes the line one byte per transmitter-ready event.
//
//   Channel  Direction  Transaction payload
//   in_i     sink       req_type, rx_byte
//   out_o    source     tx_valid, tx_byte, timer_running, listening,
//                       line_action
//
// An ordinary event passes through execute and result load before the next
// acceptance, an echoed byte also through an echo read, and a line end through
// a prefix compare over eleven stored bytes via the single line RAM read port.
// Reset is asynchronous and takes effect at once; the line RAM needs no
// clearing pass.
// A result waits in the output register while the next event is accepted;
// the block holds only when a second result is ready before the first is taken.
// ============================================================================
module uart_line_command_echo_top #(
  parameter int LINE_LEN = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ulce_in_if.sink    in_i,
  ulce_out_if.source out_o
);
  import ulce_pkg::*;

  ulce_cmd_t    cmd;
  ulce_status_t status;
  logic         in_ready;
  logic         out_valid;
  logic         tx_valid;
  logic [7:0]   tx_byte;
  logic         timer_running;
  logic         listening;
  logic [1:0]   line_action;

  ulce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ulce_dp #(
    .LINE_LEN (LINE_LEN)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .req_type_i      (in_i.req_type),
    .rx_byte_i       (in_i.rx_byte),
    .tx_valid_o      (tx_valid),
    .tx_byte_o       (tx_byte),
    .timer_running_o (timer_running),
    .listening_o     (listening),
    .line_action_o   (line_action)
  );

  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid;
  assign out_o.tx_valid      = tx_valid;
  assign out_o.tx_byte       = tx_byte;
  assign out_o.timer_running = timer_running;
  assign out_o.listening     = listening;
  assign out_o.line_action   = line_action;

endmodule
